/* hw/rtl/fsrc_pkg.sv */
// fsrc_pkg: shared types, codes and the crc-16 byte step of the framed receiver
// no dependencies; used by fsrc_store, fsrc_ctrl and the top level
`default_nettype none

package fsrc_pkg;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0]  START_MARK    = 8'hC8;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] TIMEOUT_RESET = 16'd40;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_POLL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TIMEOUT = 2'd0,
    KIND_OK      = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // one store access per beat: clear of all entries, a write and a read
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  // result of one beat before the output register
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] flen;
  } res_t;

  // crc-16 msb first over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (c[15] ^ d[7]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

  // crc after the start mark alone, from an initial value of zero
  localparam logic [15:0] CRC_MARK = crc_byte(16'h0000, START_MARK);

endpackage

`default_nettype wire

/* hw/rtl/fsrc_store.sv */
// fsrc_store: 256 x 8 frame store with per-entry valid bits and registered read
// depends on fsrc_pkg for the request struct and depth
`default_nettype none

module fsrc_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fsrc_pkg::store_req_t req_i,
  output logic [7:0]                rd_data_o
);

  logic [7:0]                      mem_q [fsrc_pkg::STORE_DEPTH];
  logic [fsrc_pkg::STORE_DEPTH-1:0] vld_q;
  logic [7:0]                      rd_q;
  logic                            rd_vld_q;

  // data array, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // valid bits, cleared by reset and by a start beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // entries never written since the last clear read as zero
  assign rd_data_o = rd_vld_q ? rd_q : 8'd0;

endmodule

`default_nettype wire

/* hw/rtl/fsrc_ctrl.sv */
// fsrc_ctrl: frame hunt, length capture, running crc and poll timeout
// depends on fsrc_pkg; drives the store request and the unregistered result
`default_nettype none

module fsrc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           operation_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic [7:0]           read_index_i,
  input  wire logic [15:0]          timeout_polls_i,
  output fsrc_pkg::store_req_t      req_o,
  output fsrc_pkg::res_t            res_o
);

  logic [7:0]  widx_q, widx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] polls_q, polls_d;
  logic        rx_q, rx_d;

  fsrc_pkg::op_e op;
  logic [15:0]   expect_val;
  logic [8:0]    end_pos;

  assign op         = fsrc_pkg::op_e'(operation_i);
  assign end_pos    = {1'b0, len_q} + 9'd1;
  // low check byte sits at index 1 (the length itself) for length zero
  assign expect_val = {hi_q, (len_q == 8'd0) ? 8'd0 : rx_byte_i};

  // next state, store request and result for one beat
  always_comb begin
    widx_d  = widx_q;
    len_d   = len_q;
    hi_d    = hi_q;
    crc_d   = crc_q;
    polls_d = polls_q;
    rx_d    = rx_q;
    req_o   = '0;
    res_o   = '0;
    req_o.rd_addr = read_index_i;
    req_o.wr_addr = widx_q;
    req_o.wr_data = rx_byte_i;

    if (accept_i) begin
      case (op)
        fsrc_pkg::OP_START: begin
          req_o.clear = 1'b1;
          widx_d  = 8'd0;
          len_d   = 8'd0;
          crc_d   = 16'd0;
          polls_d = timeout_polls_i;
          if (timeout_polls_i == 16'd0) begin
            rx_d       = 1'b0;
            res_o.valid = 1'b1;
            res_o.kind  = fsrc_pkg::KIND_TIMEOUT;
            res_o.flen  = 8'd0;
          end else begin
            rx_d = 1'b1;
          end
        end
        fsrc_pkg::OP_READ: begin
          req_o.rd_en = 1'b1;
          res_o.valid = 1'b1;
          res_o.kind  = fsrc_pkg::KIND_READ;
          res_o.flen  = 8'd0;
        end
        fsrc_pkg::OP_POLL: begin
          if (rx_q) begin
            if (polls_q <= 16'd1) begin
              polls_d     = 16'd0;
              rx_d        = 1'b0;
              res_o.valid = 1'b1;
              res_o.kind  = fsrc_pkg::KIND_TIMEOUT;
              res_o.flen  = widx_q;
            end else begin
              polls_d = polls_q - 16'd1;
            end
          end
        end
        fsrc_pkg::OP_BYTE: begin
          if (rx_q) begin
            if (widx_q == 8'd0) begin
              // hunting for the start mark
              if (rx_byte_i == fsrc_pkg::START_MARK) begin
                req_o.wr_en = 1'b1;
                widx_d      = 8'd1;
              end
            end else if (widx_q == 8'd1) begin
              // length byte; crc covers the mark and the length as needed
              req_o.wr_en = 1'b1;
              len_d       = rx_byte_i;
              widx_d      = 8'd2;
              hi_d        = (rx_byte_i == 8'd0) ? fsrc_pkg::START_MARK : rx_byte_i;
              if (rx_byte_i >= 8'd2) begin
                crc_d = fsrc_pkg::crc_byte(fsrc_pkg::CRC_MARK, rx_byte_i);
              end else if (rx_byte_i == 8'd1) begin
                crc_d = fsrc_pkg::CRC_MARK;
              end else begin
                crc_d = 16'd0;
              end
            end else begin
              // payload and check bytes
              req_o.wr_en = 1'b1;
              widx_d      = widx_q + 8'd1;
              if (widx_q == len_q) begin
                hi_d = rx_byte_i;
              end
              if ({1'b0, widx_q} >= end_pos) begin
                rx_d        = 1'b0;
                res_o.valid = 1'b1;
                res_o.kind  = (crc_q == expect_val) ? fsrc_pkg::KIND_OK
                                                    : fsrc_pkg::KIND_CRC_ERR;
                res_o.flen  = widx_q + 8'd1;
              end else if (widx_q < len_q) begin
                crc_d = fsrc_pkg::crc_byte(crc_q, rx_byte_i);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q  <= 8'd0;
      len_q   <= 8'd0;
      hi_q    <= 8'd0;
      crc_q   <= 16'd0;
      polls_q <= 16'd0;
      rx_q    <= 1'b0;
    end else begin
      widx_q  <= widx_d;
      len_q   <= len_d;
      hi_q    <= hi_d;
      crc_q   <= crc_d;
      polls_q <= polls_d;
      rx_q    <= rx_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/framed_serial_receiver_crc16_core.sv */
// framed serial receiver with crc-16 check: results pass s1, then the output
// register; one beat accepted per cycle while in_stall_o is low.
// the rate is set by the single registered pass through the framing logic and
// one store port access per beat; read beats use the registered store read.
// reset is asynchronous, active low: idle, store reads as zero, timeout 40.
// depends on fsrc_pkg, fsrc_store and fsrc_ctrl
`default_nettype none

module framed_serial_receiver_crc16_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  read_index_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       frame_length_o,
  output logic [7:0]       read_data_o
);

  logic [15:0]          timeout_q;
  logic                 accept;
  logic                 advance;
  fsrc_pkg::store_req_t req;
  fsrc_pkg::res_t       res;
  logic [7:0]           store_rd;

  logic                 s1_valid_q;
  fsrc_pkg::kind_e      s1_kind_q;
  logic [7:0]           s1_flen_q;
  logic                 out_valid_q;
  logic [1:0]           out_kind_q;
  logic [7:0]           out_flen_q;
  logic [7:0]           out_data_q;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= fsrc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  fsrc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .operation_i     (operation_i),
    .rx_byte_i       (rx_byte_i),
    .read_index_i    (read_index_i),
    .timeout_polls_i (timeout_q),
    .req_o           (req),
    .res_o           (res)
  );

  fsrc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (store_rd)
  );

  // result stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (accept) begin
        s1_valid_q <= res.valid;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= s1_kind_q;
      out_flen_q <= s1_flen_q;
      out_data_q <= (s1_kind_q == fsrc_pkg::KIND_READ) ? store_rd : 8'd0;
    end
    if (accept) begin
      s1_kind_q <= res.kind;
      s1_flen_q <= res.flen;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign frame_length_o = out_flen_q;
  assign read_data_o    = out_data_q;

endmodule

`default_nettype wire
